@@ sv/scba_pkg.sv @@
`default_nettype none

package scba_pkg;

    localparam int MAX_SLOTS   = 4;
    localparam int LOG2_BLOCK  = 10;
    localparam int SAMPLE_BITS = 10;

    localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int NUM_W   = 4;
    localparam int SUM_W   = SAMPLE_BITS + LOG2_BLOCK;
    localparam int COUNT_W = LOG2_BLOCK + 1;
    localparam int REG_SLOTS = 4;

    localparam logic [COUNT_W-1:0] BLOCK_LEN = COUNT_W'(1) << LOG2_BLOCK;

    typedef enum logic [2:0] {
        CFG_CHANNEL_COUNT = 3'd0,
        CFG_SLOT0_INPUT   = 3'd1,
        CFG_SLOT1_INPUT   = 3'd2,
        CFG_SLOT2_INPUT   = 3'd3,
        CFG_SLOT3_INPUT   = 3'd4
    } cfg_index_t;

    typedef logic [2:0] input_num_t;
    typedef input_num_t [REG_SLOTS-1:0] slot_inputs_t;

    typedef struct packed {
        logic                   mode;
        logic [SAMPLE_BITS-1:0] sample;
        logic [2:0]             query_input;
    } in_t;

    typedef struct packed {
        logic [2:0] input_select;
        logic       average_done;
        logic [1:0] done_slot;
        logic [9:0] done_average;
        logic [9:0] query_average;
        logic       query_found;
        logic [9:0] slot0_average;
    } out_t;

    typedef struct packed {
        logic                   en;
        logic [SLOT_W-1:0]      slot;
        logic [SAMPLE_BITS-1:0] avg;
    } avg_write_t;

    function automatic input_num_t input_of(input slot_inputs_t ins,
                                            input logic [SLOT_W-1:0] idx);
        input_num_t r;
        r = '0;
        for (int i = 0; i < REG_SLOTS; i++)
        begin
            if (int'(idx) == i)
            begin
                r = ins[i];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/scanned_channel_block_averager.sv @@
// result: registered, offered in the cycle after its input is accepted
// throughput: one transaction per cycle while out_ready is high; the output
// register lets the next input be taken in the same cycle the pending result is taken
// reset (rst_n, async): accumulator, count, current slot, averages cleared,
// channel_count = 1, slot inputs = 0; no clearing pass
`default_nettype none

module scanned_channel_block_averager (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire scba_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output scba_pkg::out_t      out_data,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [2:0]     cfg_data
);

    logic [2:0]                      channel_count_reg;
    scba_pkg::slot_inputs_t          slot_inputs_reg;

    logic [scba_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [scba_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic                            discard_reg, discard_next;
    logic [scba_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic                            out_valid_reg;
    scba_pkg::out_t                  out_reg, out_next;

    logic                            accept;
    logic [scba_pkg::NUM_W-1:0]      active;
    logic [scba_pkg::SLOT_W-1:0]     cur_slot;
    logic [scba_pkg::NUM_W-1:0]      slot_inc;
    logic [scba_pkg::SUM_W-1:0]      sum_add;
    logic [scba_pkg::COUNT_W-1:0]    count_add;
    scba_pkg::avg_write_t            wr;
    scba_pkg::avg_write_t            wr_acc;
    logic [scba_pkg::SAMPLE_BITS-1:0] q_avg, slot0_avg;
    logic                            q_found;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= 3'd1;
            slot_inputs_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                scba_pkg::CFG_CHANNEL_COUNT: channel_count_reg  <= cfg_data;
                scba_pkg::CFG_SLOT0_INPUT:   slot_inputs_reg[0] <= cfg_data;
                scba_pkg::CFG_SLOT1_INPUT:   slot_inputs_reg[1] <= cfg_data;
                scba_pkg::CFG_SLOT2_INPUT:   slot_inputs_reg[2] <= cfg_data;
                scba_pkg::CFG_SLOT3_INPUT:   slot_inputs_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (channel_count_reg == '0)
        begin
            active = scba_pkg::NUM_W'(1);
        end
        else if (scba_pkg::NUM_W'(channel_count_reg) > scba_pkg::NUM_W'(scba_pkg::MAX_SLOTS))
        begin
            active = scba_pkg::NUM_W'(scba_pkg::MAX_SLOTS);
        end
        else
        begin
            active = scba_pkg::NUM_W'(channel_count_reg);
        end
    end

    always_comb
    begin
        if (scba_pkg::NUM_W'(slot_reg) >= scba_pkg::NUM_W'(scba_pkg::MAX_SLOTS))
        begin
            cur_slot = '0;
        end
        else
        begin
            cur_slot = slot_reg;
        end
    end

    assign slot_inc  = scba_pkg::NUM_W'(cur_slot) + scba_pkg::NUM_W'(1);
    assign sum_add   = sum_reg + scba_pkg::SUM_W'(in_data.sample);
    assign count_add = count_reg + scba_pkg::COUNT_W'(1);

    always_comb
    begin
        sum_next     = sum_reg;
        count_next   = count_reg;
        discard_next = discard_reg;
        slot_next    = cur_slot;
        wr.en        = 1'b0;
        wr.slot      = cur_slot;
        wr.avg       = sum_add[scba_pkg::SUM_W-1 -: scba_pkg::SAMPLE_BITS];
        if (!in_data.mode)
        begin
            if (discard_reg)
            begin
                discard_next = 1'b0;
            end
            else if (count_add >= scba_pkg::BLOCK_LEN)
            begin
                wr.en        = 1'b1;
                sum_next     = '0;
                count_next   = '0;
                discard_next = 1'b1;
                slot_next    = (slot_inc >= active) ? '0 :
                               scba_pkg::SLOT_W'(slot_inc);
            end
            else
            begin
                sum_next   = sum_add;
                count_next = count_add;
            end
        end
    end

    always_comb
    begin
        wr_acc      = wr;
        wr_acc.en   = wr.en && accept;
    end

    scba_slot_table u_slot_table (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr            (wr_acc),
        .query_input   (in_data.query_input),
        .active        (active),
        .slot_inputs   (slot_inputs_reg),
        .query_average (q_avg),
        .query_found   (q_found),
        .slot0_next    (slot0_avg)
    );

    always_comb
    begin
        out_next.input_select  = scba_pkg::input_of(slot_inputs_reg, slot_next);
        out_next.average_done  = wr.en;
        out_next.done_slot     = wr.en ? 2'(wr.slot) : 2'd0;
        out_next.done_average  = wr.en ? 10'(wr.avg) : 10'd0;
        out_next.query_average = in_data.mode ? 10'(q_avg) : 10'd0;
        out_next.query_found   = in_data.mode && q_found;
        out_next.slot0_average = 10'(slot0_avg);
        // slot0 view must include this transaction's write
        if (!wr.en)
        begin
            out_next.slot0_average = 10'(slot0_avg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            count_reg     <= '0;
            discard_reg   <= 1'b0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                sum_reg     <= sum_next;
                count_reg   <= count_next;
                discard_reg <= discard_next;
                slot_reg    <= slot_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/scba_slot_table.sv @@
`default_nettype none

module scba_slot_table (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire scba_pkg::avg_write_t               wr,
    input  wire logic [2:0]                         query_input,
    input  wire logic [scba_pkg::NUM_W-1:0]         active,
    input  wire scba_pkg::slot_inputs_t             slot_inputs,
    output logic [scba_pkg::SAMPLE_BITS-1:0]        query_average,
    output logic                                    query_found,
    output logic [scba_pkg::SAMPLE_BITS-1:0]        slot0_next
);

    logic [scba_pkg::SAMPLE_BITS-1:0] avg_reg [scba_pkg::MAX_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < scba_pkg::MAX_SLOTS; i++)
            begin
                avg_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            avg_reg[wr.slot] <= wr.avg;
        end
    end

    // last active slot with a matching input wins
    always_comb
    begin
        query_average = '0;
        query_found   = 1'b0;
        for (int s = 0; s < scba_pkg::MAX_SLOTS; s++)
        begin
            if ((scba_pkg::NUM_W'(s) < active) &&
                (scba_pkg::input_of(slot_inputs, scba_pkg::SLOT_W'(s)) == query_input))
            begin
                query_average = avg_reg[s];
                query_found   = 1'b1;
            end
        end
    end

    assign slot0_next = (wr.en && (wr.slot == '0)) ? wr.avg : avg_reg[0];

endmodule

`default_nettype wire

@@ tb/scanned_channel_block_averager_checker.sv @@
`default_nettype none

module scanned_channel_block_averager_checker
    import scba_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire in_t        in_data,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire out_t       out_data,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [2:0] cfg_data,
    output int              mismatches,
    output int              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [SUM_W-1:0]       acc_sum;
    logic [COUNT_W-1:0]     acc_count;
    logic                   skip_next;
    logic [SLOT_W-1:0]      cur_slot;
    logic [SAMPLE_BITS-1:0] slot_avg [MAX_SLOTS];
    logic [2:0]             chan_count;
    input_num_t             slot_num [REG_SLOTS];
    out_t                   expected_results [$];

    function automatic input_num_t slot_input(input int slot);
        return (slot < REG_SLOTS) ? slot_num[slot] : '0;
    endfunction

    function automatic out_t average_step(input in_t item);
        out_t                   r;
        int                     active;
        logic [SAMPLE_BITS-1:0] blk_avg;
        r = '0;
        active = (chan_count == 3'd0) ? 1 :
                 (int'(chan_count) > MAX_SLOTS) ? MAX_SLOTS : int'(chan_count);
        if (!item.mode)
        begin
            if (skip_next)
            begin
                skip_next = 1'b0;
            end
            else
            begin
                acc_sum   = acc_sum + SUM_W'(item.sample);
                acc_count = acc_count + 1'b1;
                if (acc_count >= BLOCK_LEN)
                begin
                    blk_avg            = acc_sum[LOG2_BLOCK +: SAMPLE_BITS];
                    slot_avg[cur_slot] = blk_avg;
                    r.average_done     = 1'b1;
                    r.done_slot        = 2'(cur_slot);
                    r.done_average     = blk_avg;
                    cur_slot  = (int'(cur_slot) + 1 >= active) ? '0 : cur_slot + 1'b1;
                    acc_sum   = '0;
                    acc_count = '0;
                    skip_next = 1'b1;
                end
            end
        end
        else
        begin
            for (int s = 0; s < active; s++)
            begin
                if (slot_input(s) == item.query_input)
                begin
                    r.query_average = slot_avg[s];
                    r.query_found   = 1'b1;
                end
            end
        end
        r.input_select  = slot_input(int'(cur_slot));
        r.slot0_average = slot_avg[0];
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            if (mismatches < 10)
            begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field,
                         want, got);
            end
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_t want;
        if (!rst_n)
        begin
            acc_sum    = '0;
            acc_count  = '0;
            skip_next  = 1'b0;
            cur_slot   = '0;
            chan_count = 3'd1;
            for (int s = 0; s < MAX_SLOTS; s++)
            begin
                slot_avg[s] = '0;
            end
            for (int s = 0; s < REG_SLOTS; s++)
            begin
                slot_num[s] = '0;
            end
            expected_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_CHANNEL_COUNT: chan_count  = cfg_data;
                    CFG_SLOT0_INPUT:   slot_num[0] = cfg_data;
                    CFG_SLOT1_INPUT:   slot_num[1] = cfg_data;
                    CFG_SLOT2_INPUT:   slot_num[2] = cfg_data;
                    CFG_SLOT3_INPUT:   slot_num[3] = cfg_data;
                    default:           ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: result transaction with nothing expected", $realtime);
                    end
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("input_select", 16'(want.input_select),
                                16'(out_data.input_select));
                    check_field("average_done", 16'(want.average_done),
                                16'(out_data.average_done));
                    check_field("done_slot", 16'(want.done_slot), 16'(out_data.done_slot));
                    check_field("done_average", 16'(want.done_average),
                                16'(out_data.done_average));
                    check_field("query_average", 16'(want.query_average),
                                16'(out_data.query_average));
                    check_field("query_found", 16'(want.query_found),
                                16'(out_data.query_found));
                    check_field("slot0_average", 16'(want.slot0_average),
                                16'(out_data.slot0_average));
                end
            end
            if (in_valid && in_ready)
            begin
                expected_results.push_back(average_step(in_data));
            end
            outstanding = expected_results.size();
        end
    end

endmodule

`default_nettype wire

@@ tb/scanned_channel_block_averager_test.sv @@
`default_nettype none

module scanned_channel_block_averager_test;
    timeunit 1ns;
    timeprecision 1ps;

    import scba_pkg::*;

    localparam int         CYCLE_LIMIT   = 2_000_000;
    localparam int         RANDOM_ITEMS  = 630;
    localparam int         CLOSING_ITEMS = 300;
    localparam logic [2:0] CFG_UNUSED    = 3'(CFG_SLOT3_INPUT) + 3'd1;

    typedef enum {
        FILL_RANDOM,
        FILL_MAX,
        FILL_ZERO,
        FILL_LOW,
        FILL_HIGH
    } fill_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_t        in_data;
    logic       out_valid;
    logic       out_ready;
    out_t       out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [2:0] cfg_data;

    int mismatches;
    int outstanding;
    int items_sent   = 0;
    int queries_sent = 0;
    int results_seen = 0;
    int blocks_seen  = 0;
    int settings     = 0;
    int idle_odds    = 8;
    int cycle_count  = 0;

    scanned_channel_block_averager i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    scanned_channel_block_averager_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (out_data.average_done)
            begin
                blocks_seen <= blocks_seen + 1;
            end
        end
    end

    function automatic bit take_break();
        return idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0;
    endfunction

    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (take_break())
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    function automatic in_t make_item(input bit mode, input int sample, input int query);
        in_t item;
        item.mode        = mode;
        item.sample      = SAMPLE_BITS'(sample);
        item.query_input = 3'(query);
        return item;
    endfunction

    function automatic in_t random_item(input fill_t fill);
        in_t item;
        item.mode        = ($urandom_range(0, 7) == 0);
        item.sample      = SAMPLE_BITS'($urandom);
        item.query_input = 3'($urandom);
        if (!item.mode)
        begin
            case (fill)
                FILL_MAX:  item.sample = '1;
                FILL_ZERO: item.sample = '0;
                FILL_LOW:  item.sample = SAMPLE_BITS'($urandom_range(0, 3));
                FILL_HIGH: item.sample = SAMPLE_BITS'($urandom_range(1000, 1023));
                default:   ;
            endcase
        end
        return item;
    endfunction

    task automatic send_item(input in_t item);
        if (take_break())
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        if (item.mode)
        begin
            queries_sent++;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (results_seen != items_sent) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [2:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic load_config(input logic [2:0] count, input slot_inputs_t nums,
                               input bit poke_unused);
        drain();
        write_reg(CFG_CHANNEL_COUNT, count);
        write_reg(CFG_SLOT0_INPUT, nums[0]);
        write_reg(CFG_SLOT1_INPUT, nums[1]);
        write_reg(CFG_SLOT2_INPUT, nums[2]);
        write_reg(CFG_SLOT3_INPUT, nums[3]);
        if (poke_unused)
        begin
            write_reg(CFG_UNUSED + 3'($urandom_range(0, 2)), 3'($urandom));
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    initial
    begin : stimulus
        int    run_len;
        int    random_sent;
        fill_t fill;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        rst_n       = 1'b0;
        random_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one slot on input 0
        send_item(make_item(1'b1, 0, 0));
        send_item(make_item(1'b1, 1023, 7));
        send_item(make_item(1'b0, 0, 7));
        send_item(make_item(1'b0, 1023, 0));
        send_item(make_item(1'b0, 1023, 7));
        send_item(make_item(1'b0, 512, 5));

        // zero channel count acts as one slot
        load_config(3'd0, {3'd5, 3'd0, 3'd7, 3'd7}, 1'b1);
        send_item(make_item(1'b1, 0, 7));
        send_item(make_item(1'b1, 0, 5));
        send_item(make_item(1'b0, 1023, 2));

        // oversized channel count, last matching slot wins
        load_config(3'd7, {3'd5, 3'd0, 3'd7, 3'd7}, 1'b0);
        send_item(make_item(1'b1, 0, 7));
        send_item(make_item(1'b1, 1023, 5));
        send_item(make_item(1'b1, 0, 0));
        send_item(make_item(1'b1, 0, 3));
        send_item(make_item(1'b0, 0, 0));
        send_item(make_item(1'b0, 1023, 7));

        load_config(3'd4, {3'd0, 3'd1, 3'd2, 3'd3}, 1'b0);
        send_item(make_item(1'b1, 1023, 3));
        send_item(make_item(1'b0, 1, 1));

        while (random_sent < RANDOM_ITEMS)
        begin
            load_config(3'($urandom), slot_inputs_t'($urandom), $urandom_range(0, 5) == 0);
            case ($urandom_range(0, 2))
                0:       idle_odds = 0;
                1:       idle_odds = 4;
                default: idle_odds = 16;
            endcase
            fill    = fill_t'($urandom_range(0, 4));
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) :
                                                     $urandom_range(100, 300);
            if (run_len > RANDOM_ITEMS - random_sent)
            begin
                run_len = RANDOM_ITEMS - random_sent;
            end
            repeat (run_len)
            begin
                send_item(random_item(fill));
                random_sent++;
            end
        end

        // closing stretch without any idling
        idle_odds = 0;
        repeat (CLOSING_ITEMS)
        begin
            send_item(random_item(FILL_RANDOM));
        end

        drain();
        repeat (4) @(posedge clk);
        $display("covered %0d transactions (%0d queries) under %0d register settings",
                 items_sent, queries_sent, settings);
        $display("%0d block averages completed across the scanned slots", blocks_seen);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
